// File: rtl/rbcq_pkg.sv
// ----------------------------------------------------------------------------
// rbcq_pkg
// types, constants and helpers shared by the redraw box coalescing queue
// ----------------------------------------------------------------------------
package rbcq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W       = 36;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [7:0]         window_id;
        logic signed [31:0] box_x_low;
        logic signed [31:0] box_y_low;
        logic signed [31:0] box_x_high;
        logic signed [31:0] box_y_high;
    } t_in_req;

    typedef struct packed {
        logic [7:0]         out_window;
        logic signed [31:0] out_x_low;
        logic signed [31:0] out_y_low;
        logic signed [31:0] out_x_high;
        logic signed [31:0] out_y_high;
        logic               last_of_run;
    } t_out_req;

    typedef struct packed {
        logic [7:0]         window;
        logic signed [31:0] x_low;
        logic signed [31:0] y_low;
        logic signed [31:0] x_high;
        logic signed [31:0] y_high;
    } t_entry;

    typedef struct packed {
        logic                    win_eq;
        logic signed [31:0]      x_min;
        logic signed [31:0]      y_min;
        logic signed [31:0]      x_max;
        logic signed [31:0]      y_max;
        logic signed [CMP_W-1:0] bw;
        logic signed [CMP_W-1:0] sw;
        logic signed [CMP_W-1:0] bh;
        logic signed [CMP_W-1:0] sh;
    } t_eval;

    typedef struct packed {
        logic   hit;
        t_entry box;
    } t_merge;

    function automatic logic signed [CMP_W-1:0] sx(input logic signed [31:0] v);
        return {{(CMP_W - 32){v[31]}}, v};
    endfunction

endpackage

// File: rtl/redraw_box_coalescing_queue.sv
// ----------------------------------------------------------------------------
// redraw_box_coalescing_queue
// bounded queue of window tagged dirty boxes with merge on insert
// ----------------------------------------------------------------------------
// requests come in on i_valid / o_ready with i_req; emitted entries leave on
// o_valid / i_ready with o_req, one per entry in slot order, last_of_run set
// on the final one of a flush or of a full-queue drain.
// one request is worked at a time; o_ready is high while the controller idles.
// all entries live in a single ram with a registered read.
// insert: each slot of a pass is read, evaluated and tested; a merge moves the
//   last entry into the merged slot and restarts the pass from slot 0; the last
//   pass closes at the fill count and the box is appended; a full queue first drains.
// remove: each slot is read and tested; a match takes the last entry in its place.
// flush: each entry is read and emitted; an empty queue stays idle.
// results sit in an output register; a stalled receiver holds the drain and
// the next request is taken once the last result is registered.
// reset empties the queue; ram contents are not cleared and are never read
// above the fill count.
// ----------------------------------------------------------------------------
module redraw_box_coalescing_queue
    import rbcq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_req  i_req,
    output logic     o_valid,
    input  logic     i_ready,
    output t_out_req o_req
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SCAN_RD   = 4'd1;
    localparam logic [3:0] S_SCAN_EVAL = 4'd2;
    localparam logic [3:0] S_SCAN_TEST = 4'd3;
    localparam logic [3:0] S_MOVE_RD   = 4'd4;
    localparam logic [3:0] S_MOVE_WR   = 4'd5;
    localparam logic [3:0] S_REM_RD    = 4'd6;
    localparam logic [3:0] S_REM_TEST  = 4'd7;
    localparam logic [3:0] S_EMIT_RD   = 4'd8;
    localparam logic [3:0] S_EMIT_PUT  = 4'd9;
    localparam logic [3:0] S_APPEND    = 4'd10;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [1:0]       r_cmd, n_cmd;
    t_entry           r_box, n_box;
    logic             r_o_valid, n_o_valid;
    t_out_req         r_o_req, n_o_req;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_entry           ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    t_entry           ram_rdata;
    logic             eval_load;
    t_merge           merge;
    logic             out_load;
    logic [CNT_W-1:0] cnt_m1;
    logic             is_last;

    rbcq_entry_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rbcq_merge_eval u_eval (
        .i_clk   (i_clk),
        .i_load  (eval_load),
        .i_box   (r_box),
        .i_entry (ram_rdata),
        .o_merge (merge)
    );

    assign cnt_m1  = r_count - CNT_W'(1);
    assign is_last = (r_idx == cnt_m1);
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_o_valid;
    assign o_req   = r_o_req;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_cmd     = r_cmd;
        n_box     = r_box;
        n_o_valid = r_o_valid;
        n_o_req   = r_o_req;
        ram_we    = 1'b0;
        ram_waddr = r_idx[IDX_W-1:0];
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = r_idx[IDX_W-1:0];
        eval_load = 1'b0;
        out_load  = 1'b0;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd        = i_req.command;
                    n_box.window = i_req.window_id;
                    n_box.x_low  = i_req.box_x_low;
                    n_box.y_low  = i_req.box_y_low;
                    n_box.x_high = i_req.box_x_high;
                    n_box.y_high = i_req.box_y_high;
                    n_idx        = '0;
                    case (i_req.command)
                        CMD_INSERT: n_state = S_SCAN_RD;
                        CMD_REMOVE: n_state = S_REM_RD;
                        CMD_FLUSH:  n_state = (r_count == '0) ? S_IDLE : S_EMIT_RD;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN_RD: begin
                if (r_idx >= r_count) begin
                    if (r_count >= CNT_W'(QUEUE_DEPTH)) begin
                        n_idx   = '0;
                        n_state = S_EMIT_RD;
                    end else begin
                        n_state = S_APPEND;
                    end
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_SCAN_EVAL;
                end
            end
            S_SCAN_EVAL: begin
                eval_load = 1'b1;
                n_state   = S_SCAN_TEST;
            end
            S_SCAN_TEST: begin
                if (merge.hit) begin
                    n_box   = merge.box;
                    n_state = S_MOVE_RD;
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_MOVE_RD: begin
                ram_re    = 1'b1;
                ram_raddr = cnt_m1[IDX_W-1:0];
                n_state   = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                ram_we  = 1'b1;
                n_count = cnt_m1;
                if (r_cmd == CMD_REMOVE) begin
                    n_state = S_REM_RD;
                end else begin
                    n_idx   = '0;
                    n_state = S_SCAN_RD;
                end
            end
            S_REM_RD: begin
                if (r_idx >= r_count) begin
                    n_state = S_IDLE;
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_REM_TEST;
                end
            end
            S_REM_TEST: begin
                if (ram_rdata.window == r_box.window) begin
                    n_state = S_MOVE_RD;
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = S_REM_RD;
                end
            end
            S_EMIT_RD: begin
                ram_re  = 1'b1;
                n_state = S_EMIT_PUT;
            end
            S_EMIT_PUT: begin
                if (!r_o_valid || i_ready) begin
                    out_load            = 1'b1;
                    n_o_valid           = 1'b1;
                    n_o_req.out_window  = ram_rdata.window;
                    n_o_req.out_x_low   = ram_rdata.x_low;
                    n_o_req.out_y_low   = ram_rdata.y_low;
                    n_o_req.out_x_high  = ram_rdata.x_high;
                    n_o_req.out_y_high  = ram_rdata.y_high;
                    n_o_req.last_of_run = is_last;
                    n_idx               = r_idx + CNT_W'(1);
                    if (is_last) begin
                        n_count = '0;
                        n_state = (r_cmd == CMD_INSERT) ? S_APPEND : S_IDLE;
                    end else begin
                        n_state = S_EMIT_RD;
                    end
                end
            end
            S_APPEND: begin
                ram_we    = 1'b1;
                ram_waddr = r_count[IDX_W-1:0];
                ram_wdata = r_box;
                n_count   = r_count + CNT_W'(1);
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_cmd     <= CMD_INSERT;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_cmd     <= n_cmd;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_box   <= n_box;
        r_o_req <= n_o_req;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_ram_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("ram read and write in the same cycle");

    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && is_last) |=> (r_count == '0))
        else $error("queue not empty after final emitted entry");

    a_flush_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_req.command == CMD_FLUSH) && (r_count != '0))
        |=> !o_ready)
        else $error("flush of a filled queue did not start a drain");

    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPEND) |-> (r_count < CNT_W'(QUEUE_DEPTH)))
        else $error("append into a full queue");

endmodule

// File: rtl/rbcq_entry_ram.sv
// ----------------------------------------------------------------------------
// rbcq_entry_ram
// entry storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module rbcq_entry_ram
    import rbcq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_entry           i_wdata,
    input  logic             i_re,
    input  logic [IDX_W-1:0] i_raddr,
    output t_entry           o_rdata
);

    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/rbcq_merge_eval.sv
// ----------------------------------------------------------------------------
// rbcq_merge_eval
// bounding box and summed extents of box and entry, then the merge test
// ----------------------------------------------------------------------------
module rbcq_merge_eval
    import rbcq_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_load,
    input  t_entry i_box,
    input  t_entry i_entry,
    output t_merge o_merge
);

    t_eval n_eval;
    t_eval r_eval;

    always_comb begin
        n_eval.win_eq = (i_box.window == i_entry.window);
        n_eval.x_min  = (i_box.x_low < i_entry.x_low) ? i_box.x_low : i_entry.x_low;
        n_eval.y_min  = (i_box.y_low < i_entry.y_low) ? i_box.y_low : i_entry.y_low;
        n_eval.x_max  = (i_box.x_high > i_entry.x_high) ? i_box.x_high : i_entry.x_high;
        n_eval.y_max  = (i_box.y_high > i_entry.y_high) ? i_box.y_high : i_entry.y_high;
        n_eval.bw     = sx(n_eval.x_max) - sx(n_eval.x_min);
        n_eval.bh     = sx(n_eval.y_max) - sx(n_eval.y_min);
        n_eval.sw     = (sx(i_box.x_high) - sx(i_box.x_low))
                      + (sx(i_entry.x_high) - sx(i_entry.x_low));
        n_eval.sh     = (sx(i_box.y_high) - sx(i_box.y_low))
                      + (sx(i_entry.y_high) - sx(i_entry.y_low));
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_eval <= n_eval;
        end
    end

    always_comb begin
        o_merge.hit        = r_eval.win_eq
                           && !(r_eval.bw > (r_eval.sw <<< 1))
                           && !(r_eval.bh > (r_eval.sh <<< 1));
        o_merge.box.window = i_box.window;
        o_merge.box.x_low  = r_eval.x_min;
        o_merge.box.y_low  = r_eval.y_min;
        o_merge.box.x_high = r_eval.x_max;
        o_merge.box.y_high = r_eval.y_max;
    end

endmodule

// File: test/redraw_box_coalescing_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// redraw_box_coalescing_queue_tb
// self-checking bench for the redraw box coalescing queue
// ----------------------------------------------------------------------------
// a mirror of the queue follows every accepted request. it merges inserted
// boxes, drops removed windows and drains on flush or on a full queue. every
// emitted box is checked field by field against the oldest box still due.
// a short directed part covers the extreme coordinates, inverted boxes,
// merge chains, remove with back-filled slots, empty flush and the unused
// command. after that come random bursts: queue fills that force a drain,
// merge clusters and noise. the idle rates change in three phases. one long
// receiver hold-off backs the queue up into its input.
// ----------------------------------------------------------------------------
module redraw_box_coalescing_queue_tb
    import rbcq_pkg::*;
;

    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam logic [31:0] COORD_MIN    = 32'h8000_0000;
    localparam logic [31:0] COORD_MAX    = 32'h7fff_ffff;
    localparam int          ITEM_TARGET  = 360;
    localparam int          HOLD_CYCLES  = 4000;
    localparam int          END_DRAIN    = 4000;
    localparam int          CYCLE_LIMIT  = 2000000;
    localparam int          MAX_REPORTS  = 30;

    class box_queue_mirror;
        int          slot_count;
        logic [7:0]  slot_window [QUEUE_DEPTH];
        longint      slot_xl [QUEUE_DEPTH];
        longint      slot_yl [QUEUE_DEPTH];
        longint      slot_xh [QUEUE_DEPTH];
        longint      slot_yh [QUEUE_DEPTH];
        t_out_req    boxes_due[$];
        int          mismatches;
        int          requests;
        int          checked;
        int          merges;
        int          drains;

        function new();
            slot_count = 0;
            mismatches = 0;
            requests   = 0;
            checked    = 0;
            merges     = 0;
            drains     = 0;
        endfunction

        function int pending();
            return boxes_due.size();
        endfunction

        function void drop_slot(int idx);
            slot_window[idx] = slot_window[slot_count - 1];
            slot_xl[idx]     = slot_xl[slot_count - 1];
            slot_yl[idx]     = slot_yl[slot_count - 1];
            slot_xh[idx]     = slot_xh[slot_count - 1];
            slot_yh[idx]     = slot_yh[slot_count - 1];
            slot_count--;
        endfunction

        function void drain_all();
            t_out_req box;
            int       i;
            if (slot_count != 0) begin
                drains++;
            end
            for (i = 0; i < slot_count; i++) begin
                box.out_window  = slot_window[i];
                box.out_x_low   = slot_xl[i][31:0];
                box.out_y_low   = slot_yl[i][31:0];
                box.out_x_high  = slot_xh[i][31:0];
                box.out_y_high  = slot_yh[i][31:0];
                box.last_of_run = (i == slot_count - 1);
                boxes_due.push_back(box);
            end
            slot_count = 0;
        endfunction

        function void note_request(t_in_req r);
            longint xl, yl, xh, yh;
            longint lo_x, lo_y, hi_x, hi_y;
            longint bw, sw, bh, sh;
            bit     merged;
            int     i;
            requests++;
            case (r.command)
                CMD_INSERT: begin
                    xl = longint'(signed'(r.box_x_low));
                    yl = longint'(signed'(r.box_y_low));
                    xh = longint'(signed'(r.box_x_high));
                    yh = longint'(signed'(r.box_y_high));
                    do begin
                        merged = 1'b0;
                        for (i = 0; i < slot_count; i++) begin
                            if (slot_window[i] != r.window_id) continue;
                            lo_x = (xl < slot_xl[i]) ? xl : slot_xl[i];
                            hi_x = (xh > slot_xh[i]) ? xh : slot_xh[i];
                            bw   = hi_x - lo_x;
                            sw   = (xh - xl) + (slot_xh[i] - slot_xl[i]);
                            if (bw > sw + sw) continue;
                            lo_y = (yl < slot_yl[i]) ? yl : slot_yl[i];
                            hi_y = (yh > slot_yh[i]) ? yh : slot_yh[i];
                            bh   = hi_y - lo_y;
                            sh   = (yh - yl) + (slot_yh[i] - slot_yl[i]);
                            if (bh > sh + sh) continue;
                            xl = lo_x;
                            yl = lo_y;
                            xh = xl + bw;
                            yh = yl + bh;
                            drop_slot(i);
                            merges++;
                            merged = 1'b1;
                            break;
                        end
                    end while (merged);
                    if (slot_count >= QUEUE_DEPTH) begin
                        drain_all();
                    end
                    slot_window[slot_count] = r.window_id;
                    slot_xl[slot_count]     = xl;
                    slot_yl[slot_count]     = yl;
                    slot_xh[slot_count]     = xh;
                    slot_yh[slot_count]     = yh;
                    slot_count++;
                end
                CMD_REMOVE: begin
                    i = 0;
                    while (i < slot_count) begin
                        if (slot_window[i] == r.window_id) begin
                            drop_slot(i);
                        end else begin
                            i++;
                        end
                    end
                end
                CMD_FLUSH: begin
                    drain_all();
                end
                default: ;
            endcase
        endfunction

        function void report_field(string field, longint want, longint got);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t mismatch %s: expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_emitted(t_out_req got);
            t_out_req want;
            checked++;
            if (boxes_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t unexpected box: expected none, actual window %0d x %0d..%0d y %0d..%0d",
                             $time, got.out_window, got.out_x_low, got.out_x_high,
                             got.out_y_low, got.out_y_high);
                end
                return;
            end
            want = boxes_due.pop_front();
            if (got.out_window !== want.out_window)
                report_field("window", longint'(want.out_window), longint'(got.out_window));
            if (got.out_x_low !== want.out_x_low)
                report_field("x_low", longint'(want.out_x_low), longint'(got.out_x_low));
            if (got.out_y_low !== want.out_y_low)
                report_field("y_low", longint'(want.out_y_low), longint'(got.out_y_low));
            if (got.out_x_high !== want.out_x_high)
                report_field("x_high", longint'(want.out_x_high), longint'(got.out_x_high));
            if (got.out_y_high !== want.out_y_high)
                report_field("y_high", longint'(want.out_y_high), longint'(got.out_y_high));
            if (got.last_of_run !== want.last_of_run)
                report_field("last_of_run", longint'(want.last_of_run),
                             longint'(got.last_of_run));
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_ready;
    t_in_req  i_req;
    logic     o_valid;
    logic     i_ready;
    t_out_req o_req;

    box_queue_mirror board = new();

    int item_no       = 0;
    int send_idle_pct = 14;
    int recv_idle_pct = 71;
    int cycle_count   = 0;
    bit hold_start    = 1'b0;

    redraw_box_coalescing_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_req   (o_req)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) board.check_emitted(o_req);
            if (i_valid && o_ready) board.note_request(i_req);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d boxes still due", cycle_count, board.pending());
        $display("Regression FAIL");
        $finish;
    end

    initial begin : receiver
        int held;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_start) begin
                hold_start = 1'b0;
                held = 0;
                i_ready <= 1'b0;
                while (held < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    held++;
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
            @(posedge i_clk);
        end
    end

    function automatic t_in_req make_req(input logic [1:0] cmd, input logic [7:0] win,
                                         input logic [31:0] xl, input logic [31:0] yl,
                                         input logic [31:0] xh, input logic [31:0] yh);
        t_in_req r;
        r.command    = cmd;
        r.window_id  = win;
        r.box_x_low  = xl;
        r.box_y_low  = yl;
        r.box_x_high = xh;
        r.box_y_high = yh;
        return r;
    endfunction

    // small box anywhere in the plane, almost never merges
    function automatic t_in_req scattered_box();
        logic [31:0] xl, yl;
        logic [7:0]  win;
        xl  = $urandom();
        yl  = $urandom();
        win = ($urandom_range(1) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 7));
        return make_req(CMD_INSERT, win, xl, yl,
                        xl + $urandom_range(1, 64), yl + $urandom_range(1, 64));
    endfunction

    task automatic send_request(input t_in_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        item_no++;
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic random_burst();
        int          kind;
        int          count;
        logic [7:0]  win;
        int          base_x, base_y;
        logic [31:0] xl, yl, w, h;
        kind = $urandom_range(99);
        if (kind < 30) begin
            count = $urandom_range(30, 40);
            repeat (count) send_request(scattered_box());
        end else if (kind < 80) begin
            // cluster of nearby boxes in one window
            count  = $urandom_range(3, 10);
            win    = 8'($urandom_range(0, 255));
            base_x = int'($urandom()) >>> 1;
            base_y = int'($urandom()) >>> 1;
            repeat (count) begin
                xl = base_x + $urandom_range(0, 60);
                yl = base_y + $urandom_range(0, 60);
                w  = $urandom_range(1, 40);
                h  = $urandom_range(1, 40);
                if ($urandom_range(9) == 0) begin
                    send_request(make_req(CMD_INSERT, win, xl + w, yl + h, xl, yl));
                end else begin
                    send_request(make_req(CMD_INSERT, win, xl, yl, xl + w, yl + h));
                end
            end
            case ($urandom_range(3))
                0: send_request(make_req(CMD_FLUSH, 8'($urandom()), $urandom(), $urandom(),
                                         $urandom(), $urandom()));
                1: send_request(make_req(CMD_REMOVE, win, $urandom(), $urandom(),
                                         $urandom(), $urandom()));
                default: ;
            endcase
        end else begin
            count = $urandom_range(2, 6);
            repeat (count) begin
                send_request(make_req(2'($urandom_range(0, 3)), 8'($urandom()), $urandom(),
                                      $urandom(), $urandom(), $urandom()));
            end
        end
    endtask

    initial begin : stimulus
        int phase;
        phase = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_req   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        send_request(make_req(CMD_FLUSH, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0));
        send_request(make_req(CMD_INSERT, 8'd0, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
        send_request(make_req(CMD_INSERT, 8'd255, 32'd100, 32'd50, -32'd100, -32'd50));
        send_request(make_req(CMD_INSERT, 8'd255, 32'd90, 32'd40, -32'd90, -32'd40));
        send_request(make_req(CMD_INSERT, 8'd7, 32'd0, 32'd0, 32'd10, 32'd10));
        send_request(make_req(CMD_INSERT, 8'd7, 32'd5, 32'd5, 32'd15, 32'd15));
        send_request(make_req(CMD_INSERT, 8'd7, 32'd100, 32'd100, 32'd110, 32'd110));
        send_request(make_req(CMD_INSERT, 8'd7, 32'd12, 32'd12, 32'd20, 32'd20));
        send_request(make_req(CMD_INSERT, 8'd7, 32'd18, 32'd18, 32'd105, 32'd105));
        send_request(make_req(CMD_INSERT, 8'd9, 32'd0, 32'd0, 32'd10, 32'd10));
        send_request(make_req(CMD_UNUSED, 8'hff, 32'hffff_ffff, 32'hffff_ffff,
                              32'hffff_ffff, 32'hffff_ffff));
        send_request(make_req(CMD_FLUSH, 8'hff, 32'hffff_ffff, 32'hffff_ffff,
                              32'hffff_ffff, 32'hffff_ffff));
        // remove with a back-filled slot that must be looked at again
        send_request(make_req(CMD_INSERT, 8'd3, 32'd0, 32'd0, 32'd1, 32'd1));
        send_request(make_req(CMD_INSERT, 8'd3, 32'd1000, 32'd1000, 32'd1001, 32'd1001));
        send_request(make_req(CMD_INSERT, 8'd4, 32'd0, 32'd0, 32'd1, 32'd1));
        send_request(make_req(CMD_INSERT, 8'd3, -32'd5000, -32'd5000, -32'd4999, -32'd4999));
        send_request(make_req(CMD_REMOVE, 8'd3, 32'hffff_ffff, 32'hffff_ffff,
                              32'hffff_ffff, 32'hffff_ffff));
        send_request(make_req(CMD_REMOVE, 8'd200, 32'd0, 32'd0, 32'd0, 32'd0));
        send_request(make_req(CMD_INSERT, 8'd0, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN));
        send_request(make_req(CMD_INSERT, 8'd0, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN));
        send_request(make_req(CMD_INSERT, 8'd128, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
        send_request(make_req(CMD_FLUSH, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0));

        // random part in three idle phases
        while (item_no < ITEM_TARGET) begin
            if (phase == 0 && item_no >= 120) begin
                wait_for_results();
                phase = 1;
                send_idle_pct = 71;
                recv_idle_pct = 14;
            end else if (phase == 1 && item_no >= 240) begin
                wait_for_results();
                phase = 2;
                send_idle_pct = 0;
                recv_idle_pct = 0;
                // receiver stalls while the queue fills and drains into it
                hold_start = 1'b1;
                repeat (40) send_request(scattered_box());
                wait_for_results();
            end else begin
                random_burst();
            end
        end

        wait_for_results();
        repeat (END_DRAIN) @(posedge i_clk);

        $display("%0d requests, %0d boxes checked, %0d merges, %0d drains, %0d mismatches",
                 board.requests, board.checked, board.merges, board.drains, board.mismatches);
        $display("covered extreme and inverted boxes, merge chains, removes, flushes and full drains");
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: redraw_box_coalescing_queue.f
rtl/rbcq_pkg.sv
rtl/rbcq_entry_ram.sv
rtl/rbcq_merge_eval.sv
rtl/redraw_box_coalescing_queue.sv
test/redraw_box_coalescing_queue_tb.sv
